// File: rtl/core/assert_macros.svh
// Assertion macros shared by the port scan detector RTL.
// Define ASSERT_OFF to compile all assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PSD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSD_ASSERT(lbl, clk, rst, prop, msg)
`define PSD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/psd_pkg.sv
// Shared constants, types and codes of the port scan detector.
// No dependencies.
package psd_pkg;
  localparam int SRC_ENTRIES = 16;
  localparam int HIST_SLOTS  = 16;
  localparam int SRC_AW  = (SRC_ENTRIES > 1) ? $clog2(SRC_ENTRIES) : 1;
  localparam int SLOT_AW = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;
  localparam int HIST_AW = SRC_AW + SLOT_AW;
  localparam int SRC_CW  = $clog2(SRC_ENTRIES + 1);
  localparam int SLOT_CW = $clog2(HIST_SLOTS + 1);
  localparam int CNT_W   = (SRC_CW > SLOT_CW) ? SRC_CW : SLOT_CW;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAN       = 2'd2;

  localparam logic [31:0] WINDOW_RST    = 32'd1000;
  localparam logic [4:0]  THRESHOLD_RST = 5'd8;
  localparam logic [31:0] BAN_RST       = 32'd60000;
  localparam logic [4:0]  COUNT_MAX     = 5'd31;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] tick;
  } hist_word_t;

  typedef struct packed {
    logic              rd_en;
    logic [SRC_AW-1:0] rd_addr;
    logic              wr_en;
    logic [SRC_AW-1:0] wr_addr;
    logic [31:0]       wr_data;
  } src_ctl_t;

  typedef struct packed {
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    hist_word_t         wr_data;
    logic [SRC_AW-1:0]  row;
    logic               clr_row;
    logic               set_valid;
    logic               clr_valid;
    logic [SLOT_AW-1:0] valid_slot;
  } hist_ctl_t;
endpackage

// File: rtl/core/psd_if.sv
// Valid/ready channel interfaces of the port scan detector.
// Depends on nothing.
interface psd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_ip;
  logic [15:0] dest_port;
  logic [31:0] now_tick;
  modport source (output valid, src_ip, dest_port, now_tick, input ready);
  modport sink   (input valid, src_ip, dest_port, now_tick, output ready);
endinterface

interface psd_out_if;
  logic        valid;
  logic        ready;
  logic        scan_flag;
  logic        table_full;
  logic [4:0]  distinct_ports;
  logic [31:0] ban_duration;
  logic [31:0] flagged_count;
  modport source (output valid, scan_flag, table_full, distinct_ports, ban_duration,
                  flagged_count, input ready);
  modport sink   (input valid, scan_flag, table_full, distinct_ports, ban_duration,
                  flagged_count, output ready);
endinterface

// File: rtl/core/psd_src_table.sv
// Source address memory with per-entry valid flops and first-free pick.
// Depends on psd_pkg.
module psd_src_table
  import psd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  src_ctl_t               ctl,
  output logic [31:0]            rd_data,
  output logic [SRC_ENTRIES-1:0] valid,
  output logic                   any_free,
  output logic [SRC_AW-1:0]      first_free
);
  logic [31:0] mem [SRC_ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[ctl.wr_addr] <= 1'b1;
    end
  end

  // lowest-numbered free entry
  always_comb begin
    any_free   = 1'b0;
    first_free = '0;
    for (int i = SRC_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        any_free   = 1'b1;
        first_free = SRC_AW'(i);
      end
    end
  end
endmodule

// File: rtl/core/psd_hist.sv
// Port history memory, slot valid flops and live count of one row.
// Depends on psd_pkg.
module psd_hist
  import psd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  hist_ctl_t             ctl,
  output hist_word_t            rd_data,
  output logic [HIST_SLOTS-1:0] row_valid,
  output logic [SLOT_CW-1:0]    live
);
  hist_word_t mem [1 << HIST_AW];
  logic [SRC_ENTRIES-1:0][HIST_SLOTS-1:0] hv;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= '0;
    end else if (ctl.clr_row) begin
      hv[ctl.row] <= '0;
    end else if (ctl.set_valid) begin
      hv[ctl.row][ctl.valid_slot] <= 1'b1;
    end else if (ctl.clr_valid) begin
      hv[ctl.row][ctl.valid_slot] <= 1'b0;
    end
  end

  assign row_valid = hv[ctl.row];

  always_comb begin
    live = '0;
    for (int s = 0; s < HIST_SLOTS; s++) begin
      live = live + SLOT_CW'(row_valid[s]);
    end
  end
endmodule

// File: rtl/core/port_scan_detector_core.sv
// Port scan detector: per-source distinct-port tracking over a tick window.
// Flow per item: source search, history walk (one memory read a cycle), update and
// count; a full table skips the history walk and update.
// One item in flight: a new packet is accepted only in the idle state;
// a held result stalls the count state.
// Reset (synchronous, rst high): valid bits, ban total, state, result valid and configuration to defaults.
`include "assert_macros.svh"
module port_scan_detector_core
  import psd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  psd_in_if.sink               pkt,
  psd_out_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRC  = 3'd1;
  localparam logic [2:0] S_HIST = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;

  logic [2:0] state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [CNT_W-1:0] pidx;

  // configuration
  logic [31:0] window, ban;
  logic [4:0]  thr;
  logic [31:0] ban_total;

  // item context
  logic [31:0]        ip, now;
  logic [15:0]        port;
  logic [SRC_AW-1:0]  e;
  logic               is_full;
  logic               have_match, have_free;
  logic [SLOT_AW-1:0] match_slot, open_slot, min_slot;
  logic [31:0]        min_tick;

  // result register
  logic        ovalid, oscan, ofull;
  logic [4:0]  oports;
  logic [31:0] oban, ocount;

  src_ctl_t              sctl;
  hist_ctl_t             hctl;
  logic [31:0]           src_rd;
  logic [SRC_ENTRIES-1:0] src_valid;
  logic                  any_free;
  logic [SRC_AW-1:0]     first_free;
  hist_word_t            hrd;
  logic [HIST_SLOTS-1:0] row_valid;
  logic [SLOT_CW-1:0]    live;

  psd_src_table u_src (
    .clk(clk), .rst(rst), .ctl(sctl), .rd_data(src_rd), .valid(src_valid),
    .any_free(any_free), .first_free(first_free)
  );

  psd_hist u_hist (
    .clk(clk), .rst(rst), .ctl(hctl), .rd_data(hrd), .row_valid(row_valid), .live(live)
  );

  // slot under check in the history walk and its expiry
  logic [SRC_AW-1:0]  pe;
  logic [SLOT_AW-1:0] ps;
  logic               s_hit, s_last, h_last;
  logic               v, expired, slot_live;
  logic [31:0]        age;
  logic [4:0]         count_sat;
  logic               scan, out_free;

  assign pidx      = cnt - CNT_W'(1);
  assign pe        = pidx[SRC_AW-1:0];
  assign ps        = pidx[SLOT_AW-1:0];
  assign s_hit     = pend && src_valid[pe] && (src_rd == ip);
  assign s_last    = (cnt == CNT_W'(SRC_ENTRIES));
  assign h_last    = (cnt == CNT_W'(HIST_SLOTS));
  assign v         = row_valid[ps];
  assign age       = now - hrd.tick;
  assign expired   = v && (age >= window);
  assign slot_live = v && !expired;
  assign count_sat = (live > SLOT_CW'(COUNT_MAX)) ? COUNT_MAX : 5'(live);
  assign scan      = !is_full && !have_match && (count_sat >= thr);
  assign out_free  = !ovalid || res.ready;

  assign pkt.ready = (state == S_IDLE);

  // memory and valid-bit control
  always_comb begin
    sctl         = '0;
    sctl.rd_addr = cnt[SRC_AW-1:0];
    sctl.wr_addr = first_free;
    sctl.wr_data = ip;
    hctl         = '0;
    hctl.row     = e;
    hctl.rd_addr = {e, cnt[SLOT_AW-1:0]};
    hctl.valid_slot = ps;
    hctl.wr_data = '{port: port, tick: now};
    hctl.wr_addr = {e, have_match ? match_slot : (have_free ? open_slot : min_slot)};
    unique case (state)
      S_SRC: begin
        sctl.rd_en = (cnt < CNT_W'(SRC_ENTRIES));
        if (s_last && !s_hit && any_free) begin
          // claim: mark the entry and drop its whole history
          sctl.wr_en   = 1'b1;
          hctl.row     = first_free;
          hctl.clr_row = 1'b1;
        end
      end
      S_HIST: begin
        hctl.rd_en     = (cnt < CNT_W'(HIST_SLOTS));
        hctl.clr_valid = pend && expired;
      end
      S_UPD: begin
        hctl.wr_en      = 1'b1;
        hctl.set_valid  = !have_match;
        hctl.valid_slot = have_match ? match_slot : (have_free ? open_slot : min_slot);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (pkt.valid) state_next = S_SRC;
      S_SRC: begin
        if (s_hit || (s_last && any_free)) state_next = S_HIST;
        else if (s_last) state_next = S_CNT;
      end
      S_HIST: if (h_last) state_next = S_UPD;
      S_UPD:  state_next = S_CNT;
      S_CNT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      window    <= WINDOW_RST;
      thr       <= THRESHOLD_RST;
      ban       <= BAN_RST;
      ban_total <= '0;
      ovalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_WINDOW:    window <= cfg_data;
          CFG_THRESHOLD: thr    <= cfg_data[4:0];
          CFG_BAN:       ban    <= cfg_data;
          default: begin
          end
        endcase
      end
      // drop the taken result unless the count state refills it this edge
      if (res.valid && res.ready && (state != S_CNT)) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt  <= '0;
          pend <= 1'b0;
        end
        S_SRC: begin
          if (state_next != S_SRC) begin
            cnt  <= '0;
            pend <= 1'b0;
          end else begin
            cnt  <= cnt + CNT_W'(1);
            pend <= (cnt < CNT_W'(SRC_ENTRIES));
          end
        end
        S_HIST: begin
          cnt  <= cnt + CNT_W'(1);
          pend <= (cnt < CNT_W'(HIST_SLOTS));
        end
        S_CNT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            if (scan) ban_total <= ban_total + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item context and walk results
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ip         <= pkt.src_ip;
        port       <= pkt.dest_port;
        now        <= pkt.now_tick;
        is_full    <= 1'b0;
        have_match <= 1'b0;
        have_free  <= 1'b0;
      end
      S_SRC: begin
        if (s_hit) e <= pe;
        else if (s_last) begin
          e       <= first_free;
          is_full <= !any_free;
        end
      end
      S_HIST: begin
        if (pend) begin
          if (slot_live && (hrd.port == port) && !have_match) begin
            have_match <= 1'b1;
            match_slot <= ps;
          end
          if (!slot_live && !have_free) begin
            have_free <= 1'b1;
            open_slot <= ps;
          end
          // smallest raw tick, lowest index on ties
          if (ps == '0 || hrd.tick < min_tick) begin
            min_tick <= hrd.tick;
            min_slot <= ps;
          end
        end
      end
      S_CNT: begin
        if (out_free) begin
          oscan  <= scan;
          ofull  <= is_full;
          oports <= is_full ? 5'd0 : count_sat;
          oban   <= scan ? ban : 32'd0;
          ocount <= scan ? ban_total + 32'd1 : ban_total;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid          = ovalid;
  assign res.scan_flag      = oscan;
  assign res.table_full     = ofull;
  assign res.distinct_ports = oports;
  assign res.ban_duration   = oban;
  assign res.flagged_count  = ocount;

  `PSD_ASSERT(a_full_no_scan, clk, rst, res.valid |-> !(res.table_full && res.scan_flag), "full item raised a ban")
  `PSD_ASSERT(a_accept_starts, clk, rst, (pkt.valid && pkt.ready) |=> (state == S_SRC), "accepted item did not start search")
  `PSD_ASSERT(a_ban_step, clk, rst, (state == S_CNT && out_free && scan) |=> (ban_total == $past(ban_total) + 32'd1), "ban total did not advance")
  `PSD_ASSERT(a_single_write, clk, rst, !(hctl.clr_row && hctl.wr_en), "row clear collides with history write")
endmodule

// File: tb/psd_tb_if.sv
// Testbench side of the port scan detector channels.
// The valid/ready interfaces come from rtl/core/psd_if.sv and are shared as is.

// File: tb/port_scan_detector_core_tb.sv
// Testbench for port_scan_detector_core: drives packets and register writes,
// predicts each verdict in a scoreboard class and compares field by field.
// Depends on psd_pkg and the channel interfaces.
module port_scan_detector_core_tb;
  import psd_pkg::*;

  typedef struct packed {
    logic        scan_flag;
    logic        table_full;
    logic [4:0]  distinct_ports;
    logic [31:0] ban_duration;
    logic [31:0] flagged_count;
  } verdict_t;

  // Scoreboard: a shadow of the detector tables plus a queue of verdicts.
  class scan_scoreboard;
    logic [31:0] window, ban_len;
    logic [4:0]  threshold;
    logic [31:0] src_addr [SRC_ENTRIES];
    bit          src_used [SRC_ENTRIES];
    logic [15:0] slot_port [SRC_ENTRIES][HIST_SLOTS];
    logic [31:0] slot_tick [SRC_ENTRIES][HIST_SLOTS];
    bit          slot_live [SRC_ENTRIES][HIST_SLOTS];
    logic [31:0] bans;
    verdict_t    pending [$];
    int          errors;

    function void clear();
      window = WINDOW_RST; threshold = THRESHOLD_RST; ban_len = BAN_RST;
      bans = 0;
      foreach (src_used[i]) begin
        src_used[i] = 0;
        for (int s = 0; s < HIST_SLOTS; s++) begin
          slot_live[i][s] = 0;
          slot_tick[i][s] = 0;
        end
      end
      pending.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == CFG_WINDOW) window = val;
      else if (idx == CFG_THRESHOLD) threshold = val[4:0];
      else if (idx == CFG_BAN) ban_len = val;
    endfunction

    function int live(int e);
      int n;
      n = 0;
      for (int s = 0; s < HIST_SLOTS; s++) if (slot_live[e][s]) n++;
      return (n > 31) ? 31 : n;
    endfunction

    // Note an accepted packet and queue the verdict it must produce.
    function void note_packet(logic [31:0] ip, logic [15:0] port, logic [31:0] now);
      verdict_t v;
      int e, free_e, tgt;
      logic [31:0] oldest;
      v = '0;
      e = -1; free_e = -1;
      for (int i = 0; i < SRC_ENTRIES; i++) begin
        if (e < 0 && src_used[i] && src_addr[i] == ip) e = i;
        if (!src_used[i] && free_e < 0) free_e = i;
      end
      if (e < 0 && free_e >= 0) begin
        e = free_e;
        src_used[e] = 1; src_addr[e] = ip;
        for (int s = 0; s < HIST_SLOTS; s++) begin
          slot_live[e][s] = 0; slot_tick[e][s] = 0; slot_port[e][s] = 0;
        end
      end
      if (e < 0) begin
        v.table_full = 1; v.flagged_count = bans;
        pending.push_back(v);
        return;
      end
      // drop expired slots
      for (int s = 0; s < HIST_SLOTS; s++)
        if (slot_live[e][s] && (now - slot_tick[e][s]) >= window) slot_live[e][s] = 0;
      for (int s = 0; s < HIST_SLOTS; s++)
        if (slot_live[e][s] && slot_port[e][s] == port) begin
          slot_tick[e][s] = now;
          v.distinct_ports = 5'(live(e)); v.flagged_count = bans;
          pending.push_back(v);
          return;
        end
      tgt = -1;
      for (int s = 0; s < HIST_SLOTS; s++)
        if (tgt < 0 && !slot_live[e][s]) tgt = s;
      if (tgt < 0) begin
        tgt = 0; oldest = slot_tick[e][0];
        for (int s = 1; s < HIST_SLOTS; s++)
          if (slot_tick[e][s] < oldest) begin
            oldest = slot_tick[e][s]; tgt = s;
          end
      end
      slot_port[e][tgt] = port; slot_tick[e][tgt] = now; slot_live[e][tgt] = 1;
      v.distinct_ports = 5'(live(e));
      if (v.distinct_ports >= threshold) begin
        bans = bans + 1;
        v.scan_flag = 1; v.ban_duration = ban_len;
      end
      v.flagged_count = bans;
      pending.push_back(v);
    endfunction

    // Compare one accepted verdict with the oldest expectation.
    function void check_verdict(verdict_t got);
      verdict_t exp_v;
      if (pending.size() == 0) begin
        $error("unexpected verdict %p", got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.scan_flag !== exp_v.scan_flag) begin
        $error("scan_flag exp %0d got %0d", exp_v.scan_flag, got.scan_flag); errors++;
      end
      if (got.table_full !== exp_v.table_full) begin
        $error("table_full exp %0d got %0d", exp_v.table_full, got.table_full); errors++;
      end
      if (got.distinct_ports !== exp_v.distinct_ports) begin
        $error("distinct_ports exp %0d got %0d", exp_v.distinct_ports,
               got.distinct_ports);
        errors++;
      end
      if (got.ban_duration !== exp_v.ban_duration) begin
        $error("ban_duration exp %0h got %0h", exp_v.ban_duration, got.ban_duration);
        errors++;
      end
      if (got.flagged_count !== exp_v.flagged_count) begin
        $error("flagged_count exp %0h got %0h", exp_v.flagged_count, got.flagged_count);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LATENCY     = 60;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_WINDOW;
  logic [31:0] cfg_data = '0;

  psd_in_if  pkt ();
  psd_out_if res ();

  scan_scoreboard board;
  int  cycles;
  bit  hold_off;
  bit  sending_done;
  // sources in play: a small pool so entries repeat, plus random outsiders
  logic [31:0] ip_pool [24];
  logic [31:0] tick_now;

  port_scan_detector_core u_top (
    .clk(clk), .rst(rst), .pkt(pkt.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    pkt.valid = 0; pkt.src_ip = '0; pkt.dest_port = '0; pkt.now_tick = '0;
    res.ready = 0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Note every accepted packet and check every accepted verdict at the edge.
  always @(posedge clk) begin
    if (!rst && pkt.valid && pkt.ready) board.note_packet(pkt.src_ip, pkt.dest_port,
                                                          pkt.now_tick);
    if (!rst && res.valid && res.ready)
      board.check_verdict({res.scan_flag, res.table_full, res.distinct_ports,
                           res.ban_duration, res.flagged_count});
  end

  // Receiver: random stalls per item, with a long hold-off when asked.
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        res.ready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (w > 0) begin
        res.ready <= 0;
        repeat (w) @(negedge clk);
      end
      res.ready <= 1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one packet, after a random gap if gaps is set; hold it until accepted.
  task automatic send_packet(logic [31:0] ip, logic [15:0] port, logic [31:0] now,
                             bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    // step off the edge where the previous item was dropped
    @(negedge clk);
    repeat (gap) @(negedge clk);
    pkt.valid <= 1; pkt.src_ip <= ip; pkt.dest_port <= port; pkt.now_tick <= now;
    @(posedge clk);
    while (!pkt.ready) @(posedge clk);
    @(negedge clk);
    pkt.valid <= 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Wait until every verdict is in, then let the block settle.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic random_phase(int n, int ports);
    logic [31:0] ip;
    for (int k = 0; k < n; k++) begin
      ip = ($urandom_range(0, 15) == 0) ? $urandom : ip_pool[$urandom_range(0, 23)];
      tick_now = tick_now + $urandom_range(0, 40);
      if ($urandom_range(0, 30) == 0) tick_now = $urandom;
      send_packet(ip, ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, ports)), tick_now, $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    hold_off = 0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    ip_pool[0] = '0; ip_pool[1] = '1;
    tick_now = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: defaults, extreme fields, refresh, scan, victim replacement.
    write_reg(CFG_THRESHOLD, 32'd4);
    send_packet(32'h0, 16'h0, 32'h0, 1'b0);
    send_packet(32'h0, 16'h0, 32'h5, 1'b0);        // refresh of a live port
    for (int p = 1; p < 18; p++)                    // fill slots, then replace oldest
      send_packet(32'h0, 16'(16'hFFFF - p), 32'd10 + p, 1'b0);
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_packet(32'hFFFF_FFFF, 16'h1, 32'd100, 1'b0);  // tick wrap, ages fine
    drain();
    write_reg(CFG_WINDOW, 32'd0);                   // everything expires
    write_reg(CFG_THRESHOLD, 32'd0);                // every insert bans
    write_reg(CFG_BAN, 32'hFFFF_FFFF);
    send_packet(32'h0, 16'h7, 32'd50, 1'b0);
    send_packet(32'h0, 16'h7, 32'd51, 1'b0);
    drain();
    write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
    write_reg(CFG_THRESHOLD, 32'd31);               // above slot count: no ban
    write_reg(CFG_BAN, 32'd0);

    // Pressure: receiver stalls long while the sender keeps offering.
    hold_off = 1;
    random_phase(30, 40);
    drain();

    write_reg(CFG_WINDOW, 32'd200);
    write_reg(CFG_THRESHOLD, 32'd6);
    write_reg(CFG_BAN, $urandom);
    random_phase(700, 30);
    drain();

    write_reg(CFG_WINDOW, 32'd1);
    write_reg(CFG_THRESHOLD, 32'd1);
    random_phase(200, 20);
    drain();

    write_reg(CFG_WINDOW, $urandom_range(50, 5000));
    write_reg(CFG_THRESHOLD, 32'd16);
    write_reg(CFG_BAN, $urandom);
    random_phase(950, 24);
    drain();

    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_if.sv
rtl/core/psd_src_table.sv
rtl/core/psd_hist.sv
rtl/core/port_scan_detector_core.sv
tb/psd_tb_if.sv
tb/port_scan_detector_core_tb.sv
